// File: sv/cfd_pkg.sv
// Shared types, constants and the CRC-16/CCITT byte update for the frame deframer.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_START_MARKER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_MARKER   = 1'd1;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h55;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_END = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_CRC = 2'd2;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [BYTE_W-1:0] start_marker;
      logic [BYTE_W-1:0] end_marker;
   } markers_type;

   typedef struct packed {
      logic              out_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] payload_index;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] frame_seq;
      logic [WORD_W-1:0] frame_length;
      logic [STAT_W-1:0] status;
   } result_type;

   // MSB-first, one byte per call, no final xor
   function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[WORD_W-1]) begin
            c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[WORD_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/cfd_if.sv
// Channel interfaces for the deframer: receive bytes, results, register writes.
// Depends on cfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [cfd_pkg::BYTE_W-1:0]  rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        out_kind;
   logic [cfd_pkg::BYTE_W-1:0]  payload_byte;
   logic [cfd_pkg::WORD_W-1:0]  payload_index;
   logic [cfd_pkg::BYTE_W-1:0]  frame_type;
   logic [cfd_pkg::BYTE_W-1:0]  frame_seq;
   logic [cfd_pkg::WORD_W-1:0]  frame_length;
   logic [cfd_pkg::STAT_W-1:0]  status;
   modport source (output valid, output out_kind, output payload_byte,
                   output payload_index, output frame_type, output frame_seq,
                   output frame_length, output status, input ready);
   modport sink   (input valid, input out_kind, input payload_byte,
                   input payload_index, input frame_type, input frame_seq,
                   input frame_length, input status, output ready);
endinterface

interface cfd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cfd_pkg::CSR_IDX_W-1:0] index;
   logic [cfd_pkg::BYTE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/cfd_parser.sv
// Frame parser: phase sequencer, running CRC and header holding registers.
// Depends on cfd_pkg (types, CRC function). Updates once per accepted byte.
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [cfd_pkg::BYTE_W-1:0] rx_byte,
   input  wire cfd_pkg::markers_type       markers,
   output logic                            res_valid,
   output cfd_pkg::result_type             res
);

   localparam logic [3:0] PH_HUNT = 4'd0;
   localparam logic [3:0] PH_TYPE = 4'd1;
   localparam logic [3:0] PH_LENL = 4'd2;
   localparam logic [3:0] PH_LENH = 4'd3;
   localparam logic [3:0] PH_SEQ  = 4'd4;
   localparam logic [3:0] PH_DATA = 4'd5;
   localparam logic [3:0] PH_CRCL = 4'd6;
   localparam logic [3:0] PH_CRCH = 4'd7;
   localparam logic [3:0] PH_END  = 4'd8;

   logic [3:0]                 phase_ff, phase_in;
   logic [cfd_pkg::WORD_W-1:0] crc_ff, crc_in;
   logic [cfd_pkg::BYTE_W-1:0] type_ff, type_in;
   logic [cfd_pkg::BYTE_W-1:0] seq_ff, seq_in;
   logic [cfd_pkg::WORD_W-1:0] len_ff, len_in;
   logic [cfd_pkg::WORD_W-1:0] cnt_ff, cnt_in;
   logic [cfd_pkg::WORD_W-1:0] rcrc_ff, rcrc_in;
   logic [cfd_pkg::WORD_W-1:0] crc_next;
   logic [cfd_pkg::WORD_W:0]   cnt_plus1;

   assign crc_next  = cfd_pkg::crc16_byte(crc_ff, rx_byte);
   assign cnt_plus1 = {1'b0, cnt_ff} + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      rcrc_in   = rcrc_ff;
      res_valid = 1'b0;
      res               = '0;
      res.frame_type    = type_ff;
      res.frame_seq     = seq_ff;
      res.frame_length  = len_ff;
      if (accept) begin
         case (phase_ff)
            PH_TYPE: begin
               type_in  = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LENL;
            end
            PH_LENL: begin
               len_in   = {8'h00, rx_byte};
               crc_in   = crc_next;
               phase_in = PH_LENH;
            end
            PH_LENH: begin
               len_in   = {rx_byte, len_ff[7:0]};
               crc_in   = crc_next;
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               crc_in   = crc_next;
               cnt_in   = '0;
               phase_in = (len_ff == '0) ? PH_CRCL : PH_DATA;
            end
            PH_DATA: begin
               crc_in            = crc_next;
               res_valid         = 1'b1;
               res.out_kind      = cfd_pkg::KIND_PAYLOAD;
               res.payload_byte  = rx_byte;
               res.payload_index = cnt_ff;
               res.status        = cfd_pkg::STAT_OK;
               if (cnt_plus1 >= {1'b0, len_ff}) begin
                  phase_in = PH_CRCL;
               end
               cnt_in = cnt_plus1[cfd_pkg::WORD_W-1:0];
            end
            PH_CRCL: begin
               rcrc_in  = {8'h00, rx_byte};
               phase_in = PH_CRCH;
            end
            PH_CRCH: begin
               rcrc_in  = {rx_byte, rcrc_ff[7:0]};
               phase_in = PH_END;
            end
            PH_END: begin
               res_valid    = 1'b1;
               res.out_kind = cfd_pkg::KIND_VERDICT;
               // end byte outranks the CRC check
               if (rx_byte != markers.end_marker) begin
                  res.status = cfd_pkg::STAT_BAD_END;
               end else if (rcrc_ff != crc_ff) begin
                  res.status = cfd_pkg::STAT_BAD_CRC;
               end else begin
                  res.status = cfd_pkg::STAT_OK;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               // hunting, and any unused phase code
               phase_in = PH_HUNT;
               if (rx_byte == markers.start_marker) begin
                  crc_in   = cfd_pkg::CRC_INIT;
                  cnt_in   = '0;
                  phase_in = PH_TYPE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         crc_ff   <= cfd_pkg::CRC_INIT;
         type_ff  <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         rcrc_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         type_ff  <= type_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         rcrc_ff  <= rcrc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/cfd_out_stage.sv
// Result register with a skid entry, so a single stalled result does not block input.
// Depends on cfd_pkg (result_type) and cfd_if (cfd_rsp_if).
`timescale 1ns / 1ps
`default_nettype none

module cfd_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire cfd_pkg::result_type in_data,
   output logic                     in_ready,
   cfd_rsp_if.source                rsp
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   cfd_pkg::result_type main_ff, main_in;
   cfd_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign in_ready = !skid_valid_ff;
   assign pop      = main_valid_ff && rsp.ready;

   always_comb begin
      main_valid_in = main_valid_ff && !pop;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop && skid_valid_ff) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      // in_valid only arrives while the skid entry is free
      if (in_valid) begin
         if (!main_valid_in) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid         = main_valid_ff;
   assign rsp.out_kind      = main_ff.out_kind;
   assign rsp.payload_byte  = main_ff.payload_byte;
   assign rsp.payload_index = main_ff.payload_index;
   assign rsp.frame_type    = main_ff.frame_type;
   assign rsp.frame_seq     = main_ff.frame_seq;
   assign rsp.frame_length  = main_ff.frame_length;
   assign rsp.status        = main_ff.status;

endmodule

`default_nettype wire

// File: sv/crc16_frame_deframer_core.sv
// Top level of the CRC-16/CCITT frame deframer: marker registers, parser, result stage.
// Depends on cfd_pkg, cfd_if, cfd_parser and cfd_out_stage.
//
//   channel    dir  payload                                          transaction
//   req_chan   in   rx_byte                                          one received byte
//   rsp_chan   out  out_kind, payload_byte/index, frame_*, status    payload byte or verdict
//   csr_chan   in   index (0 start marker, 1 end marker), data       register write
//
// One byte per cycle while req ready is high: the parser updates its phase, CRC and
// header registers in the cycle a byte is taken, and any result lands in the result
// register or skid entry at that edge. The result stage holds one result plus one
// skid entry; req ready drops only while both are full. CSR writes are always taken.
// Synchronous reset returns to hunting with markers 0xAA / 0x55; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_deframer_core (
   input  wire logic clock,
   input  wire logic reset,
   cfd_req_if.sink   req_chan,
   cfd_rsp_if.source rsp_chan,
   cfd_csr_if.sink   csr_chan
);

   cfd_pkg::markers_type markers_ff, markers_in;
   cfd_pkg::result_type  res;
   logic                 res_valid;
   logic                 stage_ready;
   logic                 accept;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = stage_ready;
   assign accept         = req_chan.valid && stage_ready;

   always_comb begin
      markers_in = markers_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            cfd_pkg::REG_START_MARKER: markers_in.start_marker = csr_chan.data;
            cfd_pkg::REG_END_MARKER:   markers_in.end_marker   = csr_chan.data;
            default: markers_in = markers_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.start_marker <= cfd_pkg::START_MARKER_RESET;
         markers_ff.end_marker   <= cfd_pkg::END_MARKER_RESET;
      end else begin
         markers_ff <= markers_in;
      end
   end

   cfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .markers   (markers_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   cfd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res),
      .in_ready (stage_ready),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// File: sv/cfd_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on cfd_pkg for result kind and status codes.
`timescale 1ns / 1ps
`default_nettype none

module cfd_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       out_kind,
   input wire logic [cfd_pkg::BYTE_W-1:0] payload_byte,
   input wire logic [cfd_pkg::WORD_W-1:0] payload_index,
   input wire logic [cfd_pkg::STAT_W-1:0] status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_kind) && $stable(payload_byte)
                                 && $stable(payload_index) && $stable(status))
      else $error("stalled result changed");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == cfd_pkg::KIND_PAYLOAD |-> status == cfd_pkg::STAT_OK)
      else $error("payload transaction with nonzero status");

   a_verdict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == cfd_pkg::KIND_VERDICT
      |-> payload_byte == '0 && payload_index == '0
          && (status == cfd_pkg::STAT_OK || status == cfd_pkg::STAT_BAD_END
              || status == cfd_pkg::STAT_BAD_CRC))
      else $error("malformed verdict");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind crc16_frame_deframer_core cfd_checker u_cfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .out_kind      (rsp_chan.out_kind),
   .payload_byte  (rsp_chan.payload_byte),
   .payload_index (rsp_chan.payload_index),
   .status        (rsp_chan.status)
);

`default_nettype wire
